@@ sv/urss_pkg.sv @@
// Shared types, constants and tables of the ultrasonic range to scan sector block.
package urss_pkg;

   // Defaults of the top-level parameters.
   localparam int SENSOR_COUNT_DEF = 12;
   localparam int SCAN_BINS_DEF    = 720;

   // Datapath widths.
   localparam int CW     = 40;  // CORDIC x and y, Q.30
   localparam int ZW     = 28;  // CORDIC angle, degrees Q.16
   localparam int MW     = 27;  // shared multiplier operand
   localparam int PW     = 54;  // shared multiplier product
   localparam int STEP_W = 4;
   localparam int CORDIC_STEPS = 16;

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_THRESHOLD  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_SUBSTITUTE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLANK_SUBST     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_RANGE       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RANGE       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_FOV        = 3'd5;

   // Reciprocal constants: sum*65536/300, sum/3, value/360, CORDIC gain.
   localparam logic signed [MW-1:0] M_XQ     = 27'sd57266231;
   localparam int                   XQ_SHIFT = 18;
   localparam logic [9:0]           M_DIV3   = 10'd683;
   localparam logic signed [MW-1:0] M_BIN    = 27'sd1491309;
   localparam int                   BIN_SHIFT = 29;
   localparam logic signed [MW-1:0] INV_GAIN = 27'sd39797;
   localparam int                   UP_SHIFT = 14;
   localparam logic signed [ZW-1:0] DEG_180  = 28'sd11796480;

   typedef struct packed {
      logic [7:0]  clip_threshold;
      logic [8:0]  clip_substitute;
      logic [8:0]  blank_substitute;
      logic [8:0]  min_range;
      logic [8:0]  max_range;
      logic [15:0] half_fov;
   } cfg_type;

   typedef struct packed {
      logic signed [17:0] dx;
      logic signed [17:0] dy;
      logic signed [17:0] c;
      logic signed [17:0] s;
   } pose_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cordic_stat_type;

   // Mounting pose of each ring sensor; unused slots sit at the centre, angle 0.
   function automatic pose_type pose_rom(input logic [3:0] slot);
      pose_type p;
      unique case (slot)
         4'd0:  p = '{18'sd16515,  18'sd14942,  18'sd48396,  18'sd44190};
         4'd1:  p = '{18'sd17334,  18'sd9175,   18'sd65536,  18'sd0};
         4'd2:  p = '{18'sd17334,  -18'sd9175,  18'sd65536,  18'sd0};
         4'd3:  p = '{18'sd16450,  -18'sd14942, 18'sd48396,  -18'sd44190};
         4'd4:  p = '{18'sd8847,   -18'sd16417, 18'sd5942,   -18'sd65266};
         4'd5:  p = '{-18'sd8847,  -18'sd17957, 18'sd5942,   -18'sd65266};
         4'd6:  p = '{-18'sd16253, -18'sd17662, -18'sd44229, -18'sd48361};
         4'd7:  p = '{-18'sd17334, -18'sd9175,  -18'sd65536, 18'sd104};
         4'd8:  p = '{-18'sd17334, 18'sd9175,   -18'sd65536, 18'sd104};
         4'd9:  p = '{-18'sd16253, 18'sd17662,  -18'sd44229, 18'sd48361};
         4'd10: p = '{-18'sd10158, 18'sd17957,  18'sd5942,   18'sd65266};
         4'd11: p = '{18'sd8847,   18'sd16417,  18'sd5942,   18'sd65266};
         default: p = '{18'sd0, 18'sd0, 18'sd65536, 18'sd0};
      endcase
      return p;
   endfunction

   // Arctangent of 2^-i in degrees Q.16.
   function automatic logic signed [ZW-1:0] atan_deg(input logic [STEP_W-1:0] step);
      logic signed [ZW-1:0] a;
      unique case (step)
         4'd0:  a = 28'sd2949120;
         4'd1:  a = 28'sd1740967;
         4'd2:  a = 28'sd919879;
         4'd3:  a = 28'sd466945;
         4'd4:  a = 28'sd234379;
         4'd5:  a = 28'sd117304;
         4'd6:  a = 28'sd58666;
         4'd7:  a = 28'sd29335;
         4'd8:  a = 28'sd14668;
         4'd9:  a = 28'sd7334;
         4'd10: a = 28'sd3667;
         4'd11: a = 28'sd1833;
         4'd12: a = 28'sd917;
         4'd13: a = 28'sd458;
         4'd14: a = 28'sd229;
         default: a = 28'sd115;
      endcase
      return a;
   endfunction

endpackage

@@ sv/urss_if.sv @@
// Handshake interfaces of the request, response and configuration channels.
interface urss_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         sensor_index;
   logic [7:0]         raw_echo_cm;
   logic signed [15:0] left_motor_cmd;
   logic signed [15:0] right_motor_cmd;
   modport source(output valid, sensor_index, raw_echo_cm, left_motor_cmd, right_motor_cmd,
                  input ready);
   modport sink(input valid, sensor_index, raw_echo_cm, left_motor_cmd, right_motor_cmd,
                output ready);
endinterface

interface urss_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  sensor_id;
   logic        in_range;
   logic [8:0]  averaged_cm;
   logic [15:0] sector_distance;
   logic [9:0]  first_bin;
   logic [9:0]  end_bin;
   modport source(output valid, sensor_id, in_range, averaged_cm, sector_distance,
                  first_bin, end_bin, input ready);
   modport sink(input valid, sensor_id, in_range, averaged_cm, sector_distance,
                first_bin, end_bin, output ready);
endinterface

interface urss_csr_if;
   logic                               valid;
   logic                               ready;
   logic [urss_pkg::CSR_INDEX_W-1:0]   index;
   logic [urss_pkg::CSR_DATA_W-1:0]    data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

@@ sv/urss_csr.sv @@
// Configuration register file.
module urss_csr (
   input  logic              clock,
   input  logic              reset,
   urss_csr_if.sink          csr_chan,
   output urss_pkg::cfg_type cfg
);

   urss_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   // Decode one write transfer; indexes past the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            urss_pkg::CSR_CLIP_THRESHOLD:  cfg_in.clip_threshold   = csr_chan.data[7:0];
            urss_pkg::CSR_CLIP_SUBSTITUTE: cfg_in.clip_substitute  = csr_chan.data[8:0];
            urss_pkg::CSR_BLANK_SUBST:     cfg_in.blank_substitute = csr_chan.data[8:0];
            urss_pkg::CSR_MIN_RANGE:       cfg_in.min_range        = csr_chan.data[8:0];
            urss_pkg::CSR_MAX_RANGE:       cfg_in.max_range        = csr_chan.data[8:0];
            urss_pkg::CSR_HALF_FOV:        cfg_in.half_fov         = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clip_threshold   <= 8'd105;
         cfg_ff.clip_substitute  <= 9'd310;
         cfg_ff.blank_substitute <= 9'd200;
         cfg_ff.min_range        <= 9'd5;
         cfg_ff.max_range        <= 9'd100;
         cfg_ff.half_fov         <= 16'd17560;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/urss_mul.sv @@
// Shared signed multiplier with a registered product.
module urss_mul (
   input  logic                              clock,
   input  logic signed [urss_pkg::MW-1:0]    a,
   input  logic signed [urss_pkg::MW-1:0]    b,
   output logic signed [urss_pkg::PW-1:0]    prod
);

   logic signed [urss_pkg::PW-1:0] prod_ff, prod_in;

   // Both operands are sign-extended to the product width.
   assign prod_in = a * b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ sv/urss_cordic.sv @@
// Iterative vectoring CORDIC: magnitude and angle in degrees, one step a cycle.
module urss_cordic (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [urss_pkg::CW-1:0]   x_start,
   input  logic signed [urss_pkg::CW-1:0]   y_start,
   output urss_pkg::cordic_stat_type        stat,
   output logic signed [urss_pkg::CW-1:0]   mag,
   output logic signed [urss_pkg::ZW-1:0]   ang
);

   localparam int CW = urss_pkg::CW;
   localparam int ZW = urss_pkg::ZW;
   localparam int STEP_W = urss_pkg::STEP_W;

   logic signed [CW-1:0]   x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ZW-1:0]   z_ff, z_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   busy_ff, busy_in, done_ff, done_in;

   // Arithmetic shift that rounds toward zero like an integer quotient.
   function automatic logic signed [CW-1:0] tz_shift(input logic signed [CW-1:0] v,
                                                     input logic [STEP_W-1:0] sh);
      logic [CW-1:0]        mask;
      logic signed [CW-1:0] q;
      logic signed [CW-1:0] one_v;
      mask  = (CW'(1) << sh) - CW'(1);
      q     = v >>> sh;
      one_v = CW'(1);
      if (v[CW-1] && ((v & mask) != '0)) begin
         q = q + one_v;
      end
      return q;
   endfunction

   assign xs = tz_shift(x_ff, step_ff);
   assign ys = tz_shift(y_ff, step_ff);

   // Start, pre-rotation of the left half plane, and one micro-rotation a cycle.
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         step_in = '0;
         if (x_start == '0 && y_start == '0) begin
            x_in    = '0;
            z_in    = '0;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else if (x_start[CW-1]) begin
            x_in    = -x_start;
            y_in    = -y_start;
            z_in    = y_start[CW-1] ? -urss_pkg::DEG_180 : urss_pkg::DEG_180;
            busy_in = 1'b1;
         end else begin
            x_in    = x_start;
            y_in    = y_start;
            z_in    = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!y_ff[CW-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + urss_pkg::atan_deg(step_ff);
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - urss_pkg::atan_deg(step_ff);
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(urss_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign mag = x_ff;
   assign ang = z_ff;

endmodule

@@ sv/ultrasonic_range_to_scan_sector.sv @@
// Top level: echo conditioning, history, pose transform and scan sector sequencer.
//
// An echo from one ring sensor enters on the request channel together with both
// motor commands; one result leaves on the response channel for every request.
// The configuration channel writes the six range registers and is always ready;
// write it only while the block is idle.
// A request whose sensor index is out of range, or whose three-sample average
// falls outside [min, max), goes from idle straight to the done state, which
// loads the output register. An in-range request runs through the shared
// multiplier and the shared CORDIC unit: two 16-step vectoring passes plus ten
// multiplier steps. The request channel is not ready during that time, so a new
// request is taken only once the result has been loaded into the output register.
// The finished result sits in an output register, so a new request is taken
// while the receiver stalls; a second result then waits until the first one
// has been transferred.
// Reset, synchronous and active high, restores the register defaults and clears
// the per-sensor echo history.
module ultrasonic_range_to_scan_sector #(
   parameter int SENSOR_COUNT = urss_pkg::SENSOR_COUNT_DEF,
   parameter int SCAN_BINS    = urss_pkg::SCAN_BINS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   urss_req_if.sink   req_chan,
   urss_rsp_if.source rsp_chan,
   urss_csr_if.sink   csr_chan
);

   localparam int CW  = urss_pkg::CW;
   localparam int ZW  = urss_pkg::ZW;
   localparam int MW  = urss_pkg::MW;
   localparam int PW  = urss_pkg::PW;
   localparam int PXW = 21;
   localparam int AW  = ZW - 16;
   localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
   localparam int DW  = CW + 18;

   typedef enum logic [4:0] {
      S_IDLE, S_XQ, S_PX, S_PY, S_YT, S_C1S, S_C1, S_MLO, S_MHI, S_MSUM,
      S_C2, S_B1, S_B2, S_B3, S_B4, S_B5, S_DONE
   } state_type;

   urss_pkg::cfg_type         cfg;
   urss_pkg::cordic_stat_type cstat;
   urss_pkg::pose_type        pose;

   state_type            state_ff, state_in;
   logic [3:0]           id_ff, id_in;
   logic [10:0]          sum_ff, sum_in;
   logic                 in_range_ff, in_range_in;
   logic [8:0]           avg_ff, avg_in;
   logic [15:0]          dist_ff, dist_in;
   logic [9:0]           first_ff, first_in, end_ff, end_in;
   logic [18:0]          xq_ff, xq_in;
   logic signed [PXW-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [CW-1:0] yt_ff, yt_in, mag_ff, mag_in;
   logic signed [ZW-1:0] zc_ff, zc_in, zp_ff, zp_in;
   logic signed [PW-1:0] acc_ff, acc_in;
   logic signed [AW-1:0] hi_ff, hi_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [3:0]           rsp_id_ff, rsp_id_in;
   logic                 rsp_in_range_ff, rsp_in_range_in;
   logic [8:0]           rsp_avg_ff, rsp_avg_in;
   logic [15:0]          rsp_dist_ff, rsp_dist_in;
   logic [9:0]           rsp_first_ff, rsp_first_in, rsp_end_ff, rsp_end_in;

   logic [8:0]           hist_ff [SENSOR_COUNT][2];
   logic                 req_fire, idx_ok;
   logic [IDX_W-1:0]     hidx;
   logic [8:0]           cond_val;
   logic [10:0]          new_sum, min3, max3;
   logic [20:0]          avg_prod;

   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod;
   logic                 cstart;
   logic signed [CW-1:0] cx, cy, cmag;
   logic signed [ZW-1:0] cang;

   logic [DW-1:0]        mag_full;
   logic signed [CW-1:0] d30;
   logic signed [AW-1:0] phic, phi, lo_ang, hi_ang;
   logic [PW-1:0]        end_raw;

   // Integer quotient by 65536, rounded toward zero.
   function automatic logic signed [PW-1:0] trunc16(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] bias;
      bias = p[PW-1] ? PW'(65535) : '0;
      return (p + bias) >>> 16;
   endfunction

   function automatic logic signed [AW-1:0] whole_deg(input logic signed [ZW-1:0] z);
      logic signed [ZW-1:0] bias;
      logic signed [ZW-1:0] t;
      bias = z[ZW-1] ? ZW'(65535) : '0;
      t    = (z + bias) >>> 16;
      return t[AW-1:0];
   endfunction

   urss_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   urss_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   urss_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cstart),
      .x_start (cx),
      .y_start (cy),
      .stat    (cstat),
      .mag     (cmag),
      .ang     (cang)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign idx_ok = ({1'b0, req_chan.sensor_index} < 5'(SENSOR_COUNT));
   assign hidx = req_chan.sensor_index[IDX_W-1:0];
   assign pose = urss_pkg::pose_rom(id_ff);

   // Echo conditioning: clip, then blank on stopped motors or a zero value.
   always_comb begin
      cond_val = {1'b0, req_chan.raw_echo_cm};
      if (req_chan.raw_echo_cm > cfg.clip_threshold) begin
         cond_val = cfg.clip_substitute;
      end
      if (req_chan.left_motor_cmd == '0 && req_chan.right_motor_cmd == '0) begin
         cond_val = cfg.blank_substitute;
      end
      if (cond_val == '0) begin
         cond_val = cfg.blank_substitute;
      end
   end

   assign new_sum  = idx_ok ? (11'(hist_ff[hidx][0]) + 11'(hist_ff[hidx][1]) + 11'(cond_val))
                            : 11'd0;
   assign avg_prod = 21'(new_sum) * 21'(urss_pkg::M_DIV3);
   assign min3     = {1'b0, cfg.min_range, 1'b0} + 11'(cfg.min_range);
   assign max3     = {1'b0, cfg.max_range, 1'b0} + 11'(cfg.max_range);

   // Distance in Q.30 from the two partial products of magnitude times inverse gain.
   assign mag_full = (DW'(prod) << 18) + DW'(acc_ff);
   assign d30      = mag_full[CW+15:16];

   // Centre and half angles in whole degrees, then the clamped sector edges.
   always_comb begin
      phic = whole_deg(zc_ff);
      phi  = whole_deg(zp_ff);
      if (phic[AW-1]) begin
         phic = phic + AW'(360);
      end
      lo_ang = phic - phi;
      hi_ang = phic + phi;
      if (lo_ang[AW-1]) begin
         lo_ang = '0;
      end
      if (hi_ang[AW-1]) begin
         hi_ang = '0;
      end
   end

   assign end_raw = PW'(prod >>> urss_pkg::BIN_SHIFT);

   // CORDIC operands: pose point first, then distance against beam spread.
   assign cstart = (state_ff == S_C1S) || (state_ff == S_MSUM);
   assign cx = (state_ff == S_C1S) ? (CW'(px_ff) <<< urss_pkg::UP_SHIFT) : d30;
   assign cy = (state_ff == S_C1S) ? (CW'(py_ff) <<< urss_pkg::UP_SHIFT) : yt_ff;

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_XQ: begin
            mul_a = MW'(sum_ff);
            mul_b = urss_pkg::M_XQ;
         end
         S_PX: begin
            mul_a = MW'(prod[urss_pkg::XQ_SHIFT+18:urss_pkg::XQ_SHIFT]);
            mul_b = MW'(pose.c);
         end
         S_PY: begin
            mul_a = MW'(xq_ff);
            mul_b = MW'(pose.s);
         end
         S_YT: begin
            mul_a = MW'(xq_ff);
            mul_b = MW'(cfg.half_fov);
         end
         S_MLO: begin
            mul_a = MW'(mag_ff[17:0]);
            mul_b = urss_pkg::INV_GAIN;
         end
         S_MHI: begin
            mul_a = MW'(mag_ff[CW-1:18]);
            mul_b = urss_pkg::INV_GAIN;
         end
         S_B1: begin
            mul_a = MW'(lo_ang);
            mul_b = MW'(SCAN_BINS);
         end
         S_B2, S_B4: begin
            mul_a = prod[MW-1:0];
            mul_b = urss_pkg::M_BIN;
         end
         S_B3: begin
            mul_a = MW'(hi_ff);
            mul_b = MW'(SCAN_BINS);
         end
         default: ;
      endcase
   end

   // Sequencer next state and working registers.
   always_comb begin
      state_in    = state_ff;
      id_in       = id_ff;
      sum_in      = sum_ff;
      in_range_in = in_range_ff;
      avg_in      = avg_ff;
      dist_in     = dist_ff;
      first_in    = first_ff;
      end_in      = end_ff;
      xq_in       = xq_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      yt_in       = yt_ff;
      mag_in      = mag_ff;
      zc_in       = zc_ff;
      zp_in       = zp_ff;
      acc_in      = acc_ff;
      hi_in       = hi_ff;

      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_id_in       = rsp_id_ff;
      rsp_in_range_in = rsp_in_range_ff;
      rsp_avg_in      = rsp_avg_ff;
      rsp_dist_in     = rsp_dist_ff;
      rsp_first_in    = rsp_first_ff;
      rsp_end_in      = rsp_end_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               id_in       = req_chan.sensor_index;
               sum_in      = new_sum;
               avg_in      = avg_prod[19:11];
               dist_in     = '0;
               first_in    = '0;
               end_in      = '0;
               in_range_in = idx_ok && (new_sum >= min3) && (new_sum < max3);
               state_in    = in_range_in ? S_XQ : S_DONE;
            end
         end
         S_XQ: state_in = S_PX;
         S_PX: begin
            xq_in    = prod[urss_pkg::XQ_SHIFT+18:urss_pkg::XQ_SHIFT];
            state_in = S_PY;
         end
         S_PY: begin
            px_in    = PXW'(trunc16(prod)) + PXW'(pose.dx);
            state_in = S_YT;
         end
         S_YT: begin
            py_in    = PXW'(trunc16(prod)) + PXW'(pose.dy);
            state_in = S_C1S;
         end
         S_C1S: begin
            yt_in    = CW'(prod >>> 2);
            state_in = S_C1;
         end
         S_C1: begin
            if (cstat.done) begin
               mag_in   = cmag;
               zc_in    = cang;
               state_in = S_MLO;
            end
         end
         S_MLO: state_in = S_MHI;
         S_MHI: begin
            acc_in   = prod;
            state_in = S_MSUM;
         end
         S_MSUM: begin
            dist_in  = (d30[CW-1:34] != '0) ? 16'hFFFF : d30[33:18];
            state_in = S_C2;
         end
         S_C2: begin
            if (cstat.done) begin
               zp_in    = cang;
               state_in = S_B1;
            end
         end
         S_B1: begin
            hi_in    = hi_ang;
            state_in = S_B2;
         end
         S_B2: state_in = S_B3;
         S_B3: begin
            first_in = prod[urss_pkg::BIN_SHIFT+9:urss_pkg::BIN_SHIFT];
            state_in = S_B4;
         end
         S_B4: state_in = S_B5;
         S_B5: begin
            end_in   = (end_raw > PW'(SCAN_BINS)) ? 10'(SCAN_BINS - 1) : end_raw[9:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_id_in       = id_ff;
               rsp_in_range_in = in_range_ff;
               rsp_avg_in      = avg_ff;
               rsp_dist_in     = dist_ff;
               rsp_first_in    = first_ff;
               rsp_end_in      = end_ff;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      id_ff           <= id_in;
      sum_ff          <= sum_in;
      in_range_ff     <= in_range_in;
      avg_ff          <= avg_in;
      dist_ff         <= dist_in;
      first_ff        <= first_in;
      end_ff          <= end_in;
      xq_ff           <= xq_in;
      px_ff           <= px_in;
      py_ff           <= py_in;
      yt_ff           <= yt_in;
      mag_ff          <= mag_in;
      zc_ff           <= zc_in;
      zp_ff           <= zp_in;
      acc_ff          <= acc_in;
      hi_ff           <= hi_in;
      rsp_id_ff       <= rsp_id_in;
      rsp_in_range_ff <= rsp_in_range_in;
      rsp_avg_ff      <= rsp_avg_in;
      rsp_dist_ff     <= rsp_dist_in;
      rsp_first_ff    <= rsp_first_in;
      rsp_end_ff      <= rsp_end_in;
   end

   // Per-sensor history of the last two conditioned values.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            hist_ff[i][0] <= '0;
            hist_ff[i][1] <= '0;
         end
      end else if (req_fire && idx_ok) begin
         hist_ff[hidx][0] <= hist_ff[hidx][1];
         hist_ff[hidx][1] <= cond_val;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.sensor_id       = rsp_id_ff;
   assign rsp_chan.in_range        = rsp_in_range_ff;
   assign rsp_chan.averaged_cm     = rsp_avg_ff;
   assign rsp_chan.sector_distance = rsp_dist_ff;
   assign rsp_chan.first_bin       = rsp_first_ff;
   assign rsp_chan.end_bin         = rsp_end_ff;

   // A request transfer always leaves the idle state.
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_chan.ready)
      else $error("request channel still ready after a transfer");

   // The CORDIC unit only runs while requests are held off.
   a_cordic_excludes_req: assert property (@(posedge clock) disable iff (reset)
      cstat.busy |-> !req_chan.ready)
      else $error("request channel ready while the CORDIC unit runs");

   // A result without a sector carries zero geometry.
   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.in_range) |->
         (rsp_chan.sector_distance == '0 && rsp_chan.first_bin == '0 &&
          rsp_chan.end_bin == '0))
      else $error("out-of-range result carries a sector");

endmodule

@@ sim/tb.sv @@
// Testbench of the ultrasonic range to scan sector block: predicted results checked per transfer.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [3:0]  sensor_index;
      logic [7:0]  raw_echo_cm;
      logic [15:0] left_motor_cmd;
      logic [15:0] right_motor_cmd;
   } echo_item_type;

   typedef struct packed {
      logic [3:0]  sensor_id;
      logic        in_range;
      logic [8:0]  averaged_cm;
      logic [15:0] sector_distance;
      logic [9:0]  first_bin;
      logic [9:0]  end_bin;
   } sector_type;

   logic clock;
   logic reset;
   int   fail_count;

   urss_req_if req_chan ();
   urss_rsp_if rsp_chan ();
   urss_csr_if csr_chan ();

   ultrasonic_range_to_scan_sector u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   // Predictor copy of the registers and the echo history.
   urss_pkg::cfg_type model_cfg;
   logic [8:0]        hist_old [16];
   logic [8:0]        hist_new [16];
   echo_item_type     pending_echoes[$];
   sector_type        expected_sectors[$];
   logic              idle_enable;

   // The pose table written out here independently of the package.
   function automatic void mount_of(input int s, output longint dx, output longint dy,
                                    output longint c, output longint sn);
      case (s)
         0: begin dx = 16515; dy = 14942; c = 48396; sn = 44190; end
         1: begin dx = 17334; dy = 9175; c = 65536; sn = 0; end
         2: begin dx = 17334; dy = -9175; c = 65536; sn = 0; end
         3: begin dx = 16450; dy = -14942; c = 48396; sn = -44190; end
         4: begin dx = 8847; dy = -16417; c = 5942; sn = -65266; end
         5: begin dx = -8847; dy = -17957; c = 5942; sn = -65266; end
         6: begin dx = -16253; dy = -17662; c = -44229; sn = -48361; end
         7: begin dx = -17334; dy = -9175; c = -65536; sn = 104; end
         8: begin dx = -17334; dy = 9175; c = -65536; sn = 104; end
         9: begin dx = -16253; dy = 17662; c = -44229; sn = 48361; end
         10: begin dx = -10158; dy = 17957; c = 5942; sn = 65266; end
         default: begin dx = 8847; dy = 16417; c = 5942; sn = 65266; end
      endcase
   endfunction

   // Vectoring CORDIC with quotients truncated toward zero.
   function automatic void rotate_to_axis(input longint xi, input longint yi,
                                          output longint mag, output longint ang);
      longint atan_tab [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                                29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
      longint x, y, z, xs, ys, d;
      x = xi;
      y = yi;
      z = 0;
      if (x == 0 && y == 0) begin
         mag = 0;
         ang = 0;
         return;
      end
      if (x < 0) begin
         z = (y >= 0) ? 180 * 65536 : -180 * 65536;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 16; i++) begin
         d = longint'(1) << i;
         xs = x / d;
         ys = y / d;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + atan_tab[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - atan_tab[i];
         end
      end
      mag = x;
      ang = z;
   endfunction

   // Expected sector of one echo; updates the history.
   function automatic sector_type predict_sector(input echo_item_type e);
      sector_type r;
      int idx;
      logic [8:0] v;
      longint sum, xq, px, py, mag, zc, m2, zp, d30, dq, yt, phic, phi, lo, hi;
      longint dx, dy, c, sn;
      r = '0;
      r.sensor_id = e.sensor_index;
      idx = e.sensor_index;
      if (idx >= 12) return r;
      v = {1'b0, e.raw_echo_cm};
      if (e.raw_echo_cm > model_cfg.clip_threshold) v = model_cfg.clip_substitute;
      if (e.left_motor_cmd == 0 && e.right_motor_cmd == 0) v = model_cfg.blank_substitute;
      if (v == 0) v = model_cfg.blank_substitute;
      sum = longint'(hist_old[idx]) + longint'(hist_new[idx]) + longint'(v);
      hist_old[idx] = hist_new[idx];
      hist_new[idx] = v;
      r.averaged_cm = 9'(sum / 3);
      if (sum < 3 * longint'(model_cfg.min_range) || sum >= 3 * longint'(model_cfg.max_range))
         return r;
      r.in_range = 1'b1;
      mount_of(idx, dx, dy, c, sn);
      xq = (sum * 65536) / 300;
      px = (xq * c) / 65536 + dx;
      py = (xq * sn) / 65536 + dy;
      rotate_to_axis(px * 16384, py * 16384, mag, zc);
      d30 = (mag * 39797) / 65536;
      dq = d30 / 262144;
      if (dq > 65535) dq = 65535;
      r.sector_distance = 16'(dq);
      yt = (xq * longint'(model_cfg.half_fov)) / 4;
      rotate_to_axis(d30, yt, m2, zp);
      phic = zc / 65536;
      phi = zp / 65536;
      if (phic < 0) phic = phic + 360;
      lo = phic - phi;
      if (lo < 0) lo = 0;
      lo = lo * 720 / 360;
      hi = (phic + phi) * 720 / 360;
      if (hi > 720) hi = 719;
      if (hi < 0) hi = 0;
      r.first_bin = 10'(lo);
      r.end_bin = 10'(hi);
      return r;
   endfunction

   // Append one echo to the pending queue.
   task automatic queue_echo(input echo_item_type e);
      pending_echoes.insert(pending_echoes.size(), e);
   endtask

   // Clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit.
   initial begin
      #400ms;
      $display("*** FAILED ***");
      $finish;
   end

   // Request driver fed from the pending queue.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_echoes.size() > 0 && !(idle_enable && $urandom_range(99) < 10)) begin
            echo_item_type e;
            e = pending_echoes.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.sensor_index <= e.sensor_index;
            req_chan.raw_echo_cm <= e.raw_echo_cm;
            req_chan.left_motor_cmd <= e.left_motor_cmd;
            req_chan.right_motor_cmd <= e.right_motor_cmd;
            expected_sectors.insert(expected_sectors.size(), predict_sector(e));
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Response monitor and receiver stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            sector_type got, want;
            got = '{rsp_chan.sensor_id, rsp_chan.in_range, rsp_chan.averaged_cm,
                    rsp_chan.sector_distance, rsp_chan.first_bin, rsp_chan.end_bin};
            if (expected_sectors.size() == 0) begin
               $error("unexpected response transfer %p", got);
               fail_count++;
            end else begin
               want = expected_sectors.pop_front();
               if (got.sensor_id !== want.sensor_id) begin
                  $error("sensor_id expected %0d actual %0d", want.sensor_id, got.sensor_id);
                  fail_count++;
               end
               if (got.in_range !== want.in_range) begin
                  $error("in_range expected %0d actual %0d", want.in_range, got.in_range);
                  fail_count++;
               end
               if (got.averaged_cm !== want.averaged_cm) begin
                  $error("averaged_cm expected %0d actual %0d", want.averaged_cm,
                         got.averaged_cm);
                  fail_count++;
               end
               if (got.sector_distance !== want.sector_distance) begin
                  $error("sector_distance expected %0d actual %0d", want.sector_distance,
                         got.sector_distance);
                  fail_count++;
               end
               if (got.first_bin !== want.first_bin) begin
                  $error("first_bin expected %0d actual %0d", want.first_bin, got.first_bin);
                  fail_count++;
               end
               if (got.end_bin !== want.end_bin) begin
                  $error("end_bin expected %0d actual %0d", want.end_bin, got.end_bin);
                  fail_count++;
               end
            end
         end
         rsp_chan.ready <= !(idle_enable && $urandom_range(99) < 10);
      end
   end

   // Wait until the block has drained every expected result.
   task automatic wait_drained();
      while (pending_echoes.size() > 0 || expected_sectors.size() > 0 || req_chan.valid)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // One register write over the configuration channel; valid is then dropped and the predictor copy updated.
   task automatic write_reg(input logic [urss_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [15:0] value);
      csr_chan.index <= idx;
      csr_chan.data <= value;
      csr_chan.valid <= 1'b1;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      @(posedge clock);
      case (idx)
         urss_pkg::CSR_CLIP_THRESHOLD:  model_cfg.clip_threshold = value[7:0];
         urss_pkg::CSR_CLIP_SUBSTITUTE: model_cfg.clip_substitute = value[8:0];
         urss_pkg::CSR_BLANK_SUBST:     model_cfg.blank_substitute = value[8:0];
         urss_pkg::CSR_MIN_RANGE:       model_cfg.min_range = value[8:0];
         urss_pkg::CSR_MAX_RANGE:       model_cfg.max_range = value[8:0];
         urss_pkg::CSR_HALF_FOV:        model_cfg.half_fov = value;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [7:0] thr, input logic [8:0] clip, input logic [8:0] blank,
                            input logic [8:0] lo, input logic [8:0] hi, input logic [15:0] fov);
      write_reg(urss_pkg::CSR_CLIP_THRESHOLD, 16'(thr));
      write_reg(urss_pkg::CSR_CLIP_SUBSTITUTE, 16'(clip));
      write_reg(urss_pkg::CSR_BLANK_SUBST, 16'(blank));
      write_reg(urss_pkg::CSR_MIN_RANGE, 16'(lo));
      write_reg(urss_pkg::CSR_MAX_RANGE, 16'(hi));
      write_reg(urss_pkg::CSR_HALF_FOV, fov);
   endtask

   // Random echo: mostly moving robot with valid sensors, some idle-motor and bad indexes.
   function automatic echo_item_type random_echo();
      echo_item_type e;
      int pick;
      pick = $urandom_range(99);
      e.sensor_index = (pick < 5) ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
      e.raw_echo_cm = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom);
      e.left_motor_cmd = 16'($urandom);
      e.right_motor_cmd = 16'($urandom);
      if (pick >= 5 && pick < 10) begin
         e.left_motor_cmd = '0;
         e.right_motor_cmd = '0;
      end else if (pick >= 10 && pick < 14) begin
         e.left_motor_cmd = '0;
      end
      return e;
   endfunction

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) queue_echo(random_echo());
      wait_drained();
   endtask

   // Stimulus and end of run.
   initial begin
      fail_count = 0;
      idle_enable = 1'b1;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.sensor_index = '0;
      req_chan.raw_echo_cm = '0;
      req_chan.left_motor_cmd = '0;
      req_chan.right_motor_cmd = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      model_cfg = '{8'd105, 9'd310, 9'd200, 9'd5, 9'd100, 16'd17560};
      for (int s = 0; s < 16; s++) begin
         hist_old[s] = '0;
         hist_new[s] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: each sensor, extremes of echo and motors, zero echo, stop, bad index.
      for (int s = 0; s < 12; s++)
         queue_echo('{4'(s), 8'd60, 16'h7FFF, 16'h8000});
      queue_echo('{4'd0, 8'd0, 16'h0001, 16'h0000});
      queue_echo('{4'd1, 8'd255, 16'h8000, 16'h7FFF});
      queue_echo('{4'd2, 8'd105, 16'hFFFF, 16'hFFFF});
      queue_echo('{4'd3, 8'd106, 16'h0000, 16'h0001});
      queue_echo('{4'd4, 8'd50, 16'h0000, 16'h0000});
      queue_echo('{4'd12, 8'd50, 16'h0001, 16'h0001});
      queue_echo('{4'd15, 8'd255, 16'hFFFF, 16'hFFFF});
      queue_echo('{4'd5, 8'd1, 16'h0100, 16'h0100});
      queue_echo('{4'd5, 8'd1, 16'h0100, 16'h0100});
      queue_echo('{4'd5, 8'd1, 16'h0100, 16'h0100});
      wait_drained();

      random_phase(300);

      // Unlimited window, no clipping, widest beam.
      idle_enable = 1'b0;
      write_all(8'd255, 9'd511, 9'd511, 9'd0, 9'd511, 16'hFFFF);
      random_phase(300);
      idle_enable = 1'b1;

      // Clip everything to small values, zero beam.
      write_all(8'd0, 9'd0, 9'd0, 9'd0, 9'd511, 16'h0000);
      random_phase(150);

      // Typical window with random registers.
      for (int k = 0; k < 4; k++) begin
         write_all(8'($urandom_range(40, 255)), 9'($urandom), 9'($urandom),
                   9'($urandom_range(0, 20)), 9'($urandom_range(60, 511)), 16'($urandom));
         random_phase(200);
      end

      write_all(8'd105, 9'd310, 9'd200, 9'd5, 9'd100, 16'd17560);
      random_phase(100);

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
